// File: design/hash_chain_lineage_verify_macros.svh
// ----------------------------------------------------------------------------
// Lineage verifier assertion macros
// Concurrent check helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HASH_CHAIN_LINEAGE_VERIFY_MACROS_SVH
`define HASH_CHAIN_LINEAGE_VERIFY_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define HCLV_ASSERT_IMP(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lineage verifier check failed");

// Next-cycle implication.
`define HCLV_ASSERT_NEXT(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lineage verifier check failed");

`else

`define HCLV_ASSERT_IMP(label, clock, rstn, ante, cons)
`define HCLV_ASSERT_NEXT(label, clock, rstn, ante, cons)

`endif

`endif

// File: design/hclv_pkg.sv
// ----------------------------------------------------------------------------
// Lineage verifier package
// Shared types, codes and constants of the hash-chain lineage verifier.
// ----------------------------------------------------------------------------
package hclv_pkg;

    localparam int MAX_LINEAGE_DEF   = 16;
    localparam int HORIZON_SPAN_DEF  = 64;
    localparam int CARRIER_TOTAL_DEF = 8;
    localparam int ORIENT_MAX_DEF    = 3;

    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

    // Bytes hashed per entry: two 32-bit words, three bytes, a 16-bit layer
    // and the inversion byte.
    localparam int HASH_BYTES = 14;
    localparam int HASH_IDX_W = $clog2(HASH_BYTES);

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    localparam logic [7:0] INV_NONNEG = 8'h00;
    localparam logic [7:0] INV_NEG    = 8'h01;

    // The queue depth must be a power of two so that the pointers wrap.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic               kind;
        logic [31:0]        origin_link;
        logic [31:0]        final_witness;
        logic [31:0]        link_from;
        logic [31:0]        link_to;
        logic [31:0]        hop;
        logic [7:0]         carrier_sel;
        logic [7:0]         facing;
        logic [7:0]         depth_of_scope;
        logic signed [15:0] layer_value;
        logic [7:0]         inversion_flag;
        logic               last_entry;
    } hclv_item_t;

    typedef struct packed {
        logic       chain_ok;
        logic       horizons_ok;
        logic [4:0] entries_counted;
    } hclv_result_t;

    typedef struct packed {
        hclv_item_t item;
        logic       fields_ok;
        logic       horizon_ok;
    } hclv_qword_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } hclv_back_status_t;

endpackage

// File: design/hash_chain_lineage_verify.sv
// ----------------------------------------------------------------------------
// Hash-chain lineage verifier
// Checks a capsule's lineage entries against a 32-bit FNV-1a hash chain.
// ----------------------------------------------------------------------------
// A header word opens a capsule and each entry word after it is one hop of
// the lineage; a result word appears only for the word marked as last. The
// hash engine folds one byte per cycle through a single 32-bit multiply, so
// an entry is taken, has its fourteen bytes hashed and is then compared and
// used to update the chain state, while a header skips the hashing. A
// two-word queue in front of the engine and a result register behind it let
// input and output stall independently of each other.
module hash_chain_lineage_verify #(
    parameter int MAX_LINEAGE   = hclv_pkg::MAX_LINEAGE_DEF,
    parameter int HORIZON_SPAN  = hclv_pkg::HORIZON_SPAN_DEF,
    parameter int CARRIER_TOTAL = hclv_pkg::CARRIER_TOTAL_DEF,
    parameter int ORIENT_MAX    = hclv_pkg::ORIENT_MAX_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  hclv_pkg::hclv_item_t   item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output hclv_pkg::hclv_result_t result
);
    import hclv_pkg::*;

`include "hash_chain_lineage_verify_macros.svh"

    logic                  q_ready;
    logic                  q_push;
    hclv_qword_t           q_word;
    logic                  q_pop;
    logic                  q_valid;
    hclv_qword_t           q_head;
    logic [QUEUE_CW-1:0]   q_count;
    hclv_back_status_t     back_status;

    hclv_front #(
        .HORIZON_SPAN  (HORIZON_SPAN),
        .CARRIER_TOTAL (CARRIER_TOTAL),
        .ORIENT_MAX    (ORIENT_MAX)
    ) u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_word     (q_word)
    );

    hclv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_word  (q_word),
        .ready      (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head),
        .count      (q_count)
    );

    hclv_back #(
        .MAX_LINEAGE (MAX_LINEAGE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .status       (back_status)
    );

    // A full queue must hold off the input channel.
    `HCLV_ASSERT_IMP(a_full_stalls_input, clk, rst_n, q_count == QUEUE_CW'(QUEUE_DEPTH), !item_ready)
    // The engine only takes a word when one is waiting.
    `HCLV_ASSERT_IMP(a_pop_needs_word, clk, rst_n, back_status.pop, q_count != '0)
    // Taking a word always puts the engine to work in the next cycle.
    `HCLV_ASSERT_NEXT(a_pop_starts_work, clk, rst_n, back_status.pop, back_status.busy)

endmodule

// File: design/hclv_front.sv
// ----------------------------------------------------------------------------
// Lineage verifier front end
// Takes words from the input channel and tags them with range and horizon
// checks before they go into the queue.
// ----------------------------------------------------------------------------
module hclv_front #(
    parameter int HORIZON_SPAN  = hclv_pkg::HORIZON_SPAN_DEF,
    parameter int CARRIER_TOTAL = hclv_pkg::CARRIER_TOTAL_DEF,
    parameter int ORIENT_MAX    = hclv_pkg::ORIENT_MAX_DEF
) (
    input  logic                 item_valid,
    output logic                 item_ready,
    input  hclv_pkg::hclv_item_t item,
    input  logic                 q_ready,
    output logic                 q_push,
    output hclv_pkg::hclv_qword_t q_word
);
    import hclv_pkg::*;

    localparam logic signed [16:0] SPAN_POS = 17'(HORIZON_SPAN);
    localparam logic signed [16:0] SPAN_NEG = -SPAN_POS;
    localparam logic [7:0]         CARRIER_LIM = 8'(CARRIER_TOTAL);
    localparam logic [7:0]         ORIENT_LIM  = 8'(ORIENT_MAX);

    logic signed [16:0] layer_ext;
    logic               horizon_ok;

    assign layer_ext = {item.layer_value[15], item.layer_value};

    always_comb
    begin
        case (item.inversion_flag)
            INV_NONNEG: horizon_ok = !item.layer_value[15] && (layer_ext < SPAN_POS);
            INV_NEG:    horizon_ok = item.layer_value[15] && (layer_ext >= SPAN_NEG);
            default:    horizon_ok = 1'b0;
        endcase
    end

    assign item_ready         = q_ready;
    assign q_push             = item_valid && q_ready;
    assign q_word.item        = item;
    assign q_word.fields_ok   = (item.carrier_sel < CARRIER_LIM) && (item.facing <= ORIENT_LIM);
    assign q_word.horizon_ok  = horizon_ok;

endmodule

// File: design/hclv_queue.sv
// ----------------------------------------------------------------------------
// Lineage verifier queue
// Short first-in first-out buffer between the front end and the hash engine.
// ----------------------------------------------------------------------------
module hclv_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  hclv_pkg::hclv_qword_t               push_word,
    output logic                                ready,
    input  logic                                pop,
    output logic                                head_valid,
    output hclv_pkg::hclv_qword_t               head,
    output logic [hclv_pkg::QUEUE_CW-1:0]       count
);
    import hclv_pkg::*;

    hclv_qword_t         slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? QUEUE_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QUEUE_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QUEUE_CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QUEUE_CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign ready      = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

// File: design/hclv_back.sv
// ----------------------------------------------------------------------------
// Lineage verifier back end
// Serial FNV-1a engine, chain state and the result register.
// ----------------------------------------------------------------------------
module hclv_back #(
    parameter int MAX_LINEAGE = hclv_pkg::MAX_LINEAGE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  hclv_pkg::hclv_qword_t         q_head,
    output logic                          q_pop,
    output logic                          result_valid,
    input  logic                          result_ready,
    output hclv_pkg::hclv_result_t        result,
    output hclv_pkg::hclv_back_status_t   status
);
    import hclv_pkg::*;

    localparam int                 TALLY_W   = $clog2(MAX_LINEAGE + 1);
    localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(MAX_LINEAGE);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [HASH_IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]           link_reg, link_next;
    logic [31:0]           target_reg, target_next;
    logic [TALLY_W-1:0]    tally_reg, tally_next;
    logic                  links_good_reg, links_good_next;
    logic                  horizons_good_reg, horizons_good_next;
    logic                  out_valid_reg, out_valid_next;

    hclv_qword_t           work_reg, work_next;
    logic [31:0]           hash_reg, hash_next;
    hclv_result_t          out_data_reg, out_data_next;

    logic [8*HASH_BYTES-1:0] message;
    logic [7:0]            msg_byte;
    logic [31:0]           hash_step;
    logic                  over_limit;
    logic                  finish_go;
    logic                  upd_links;
    logic                  upd_horizons;
    logic [31:0]           upd_link;
    logic [31:0]           upd_target;
    logic [TALLY_W-1:0]    upd_tally;

    // Byte 0 of the hashed string sits in the lowest bits.
    assign message = {work_reg.item.inversion_flag, work_reg.item.layer_value,
                      work_reg.item.depth_of_scope, work_reg.item.facing,
                      work_reg.item.carrier_sel, work_reg.item.hop,
                      work_reg.item.link_from};
    assign msg_byte  = message[{idx_reg, 3'b000} +: 8];
    assign hash_step = (hash_reg ^ {24'h000000, msg_byte}) * FNV_PRIME;

    assign over_limit = (tally_reg >= TALLY_MAX);
    assign finish_go  = (state_reg == ST_FINISH)
                        && (!work_reg.item.last_entry || !out_valid_reg || result_ready);

    always_comb
    begin
        if (work_reg.item.kind == KIND_HEADER)
        begin
            upd_links    = 1'b1;
            upd_horizons = work_reg.horizon_ok;
            upd_link     = work_reg.item.origin_link;
            upd_target   = work_reg.item.final_witness;
            upd_tally    = '0;
        end
        else
        begin
            upd_links    = links_good_reg && !over_limit
                           && (work_reg.item.link_from == link_reg)
                           && work_reg.fields_ok
                           && (work_reg.item.link_to == hash_reg);
            upd_horizons = horizons_good_reg && work_reg.horizon_ok;
            upd_link     = work_reg.item.link_to;
            upd_target   = target_reg;
            upd_tally    = over_limit ? tally_reg : TALLY_W'(tally_reg + 1'b1);
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        link_next          = link_reg;
        target_next        = target_reg;
        tally_next         = tally_reg;
        links_good_next    = links_good_reg;
        horizons_good_next = horizons_good_reg;
        out_valid_next     = out_valid_reg && !result_ready;
        work_next          = work_reg;
        hash_next          = hash_reg;
        out_data_next      = out_data_reg;
        q_pop              = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    work_next = q_head;
                    hash_next = FNV_BASIS;
                    idx_next  = '0;
                    state_next = (q_head.item.kind == KIND_ENTRY) ? ST_HASH : ST_FINISH;
                end
            end
            ST_HASH:
            begin
                hash_next = hash_step;
                idx_next  = HASH_IDX_W'(idx_reg + 1'b1);
                if (idx_reg == HASH_IDX_W'(HASH_BYTES - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    link_next          = upd_link;
                    target_next        = upd_target;
                    tally_next         = upd_tally;
                    links_good_next    = upd_links;
                    horizons_good_next = upd_horizons;
                    if (work_reg.item.last_entry)
                    begin
                        out_valid_next                = 1'b1;
                        out_data_next.chain_ok        = upd_links && (upd_link == upd_target);
                        out_data_next.horizons_ok     = upd_horizons;
                        out_data_next.entries_counted = 5'(upd_tally);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            idx_reg           <= '0;
            link_reg          <= '0;
            target_reg        <= '0;
            tally_reg         <= '0;
            links_good_reg    <= 1'b1;
            horizons_good_reg <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            idx_reg           <= idx_next;
            link_reg          <= link_next;
            target_reg        <= target_next;
            tally_reg         <= tally_next;
            links_good_reg    <= links_good_next;
            horizons_good_reg <= horizons_good_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        hash_reg     <= hash_next;
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;
    assign status.busy  = (state_reg != ST_IDLE);
    assign status.pop   = q_pop;

endmodule
